// ===== rtl/lmss_pkg.sv =====
// Shared types, constants and helper functions for the LED matrix scroll scanner.
// No dependencies; all other files of the block import this package.
package lmss_pkg;

   // Glyph store geometry
   localparam int GLYPH_SLOTS = 64;
   localparam int SLOT_W      = 6;
   localparam int ROW_W       = 3;
   localparam int SLOT_AW     = $clog2(GLYPH_SLOTS);
   localparam int ADDR_W      = SLOT_AW + ROW_W;
   localparam int FRAME_ROWS  = 8;
   localparam int PIX_W       = 8;

   // Tick counter and register widths
   localparam int PERIOD_W    = 16;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   // Item operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register indexes
   localparam logic [1:0] REG_CHAR_COUNT    = 2'd0;
   localparam logic [1:0] REG_SCROLL_PERIOD = 2'd1;
   localparam logic [1:0] REG_ACTIVE_LOW    = 2'd2;

   // Register reset values
   localparam logic [SLOT_W-1:0]   CHAR_COUNT_RST    = 6'd15;
   localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RST = 16'd500;
   localparam logic                ACTIVE_LOW_RST    = 1'b1;

   typedef struct packed {
      logic [SLOT_W-1:0]   char_count;
      logic [PERIOD_W-1:0] scroll_period;
      logic                columns_active_low;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } mem_cmd_type;

   // (cur >> sh) | (nxt << (8 - sh)), kept to 8 bits
   function automatic logic [PIX_W-1:0] frame_byte(input logic [PIX_W-1:0] cur,
                                                   input logic [PIX_W-1:0] nxt,
                                                   input logic [ROW_W-1:0] sh);
      logic [2*PIX_W-1:0] pair;
      pair = {nxt, cur} >> sh;
      return pair[PIX_W-1:0];
   endfunction

endpackage

// ===== rtl/lmss_if.sv =====
// Channel interfaces of the scroll scanner: load/tick requests and column results.
// Depends on lmss_pkg.
interface lmss_req_if import lmss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [SLOT_W-1:0] glyph_slot;
   logic [ROW_W-1:0]  glyph_row;
   logic [PIX_W-1:0]  row_bits;

   modport source (output valid, operation, glyph_slot, glyph_row, row_bits, input ready);
   modport sink   (input valid, operation, glyph_slot, glyph_row, row_bits, output ready);
endinterface

interface lmss_rsp_if import lmss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] column_drive;
   logic [PIX_W-1:0] row_drive;

   modport source (output valid, column_drive, row_drive, input ready);
   modport sink   (input valid, column_drive, row_drive, output ready);
endinterface

// ===== rtl/lmss_csr.sv =====
// APB-style configuration registers: char_count, scroll_period, columns_active_low.
// Depends on lmss_pkg.
module lmss_csr import lmss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CHAR_COUNT:    cfg_in.char_count         = csr_pwdata[SLOT_W-1:0];
            REG_SCROLL_PERIOD: cfg_in.scroll_period      = csr_pwdata[PERIOD_W-1:0];
            REG_ACTIVE_LOW:    cfg_in.columns_active_low = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CHAR_COUNT:    csr_prdata = {{(CSR_DW-SLOT_W){1'b0}}, cfg_ff.char_count};
         REG_SCROLL_PERIOD: csr_prdata = {{(CSR_DW-PERIOD_W){1'b0}}, cfg_ff.scroll_period};
         REG_ACTIVE_LOW:    csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.columns_active_low};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_count         <= CHAR_COUNT_RST;
         cfg_ff.scroll_period      <= SCROLL_PERIOD_RST;
         cfg_ff.columns_active_low <= ACTIVE_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== rtl/lmss_glyph_mem.sv =====
// Glyph store: one synchronous RAM of GLYPH_SLOTS * 8 bytes, one access per cycle.
// Depends on lmss_pkg.
module lmss_glyph_mem import lmss_pkg::*; (
   input  logic             clock,
   input  mem_cmd_type      cmd,
   output logic [PIX_W-1:0] rd_data
);
   localparam int DEPTH = GLYPH_SLOTS * FRAME_ROWS;

   logic [PIX_W-1:0] mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem_ff[cmd.addr] <= cmd.wdata;
      end
      rd_data_ff <= mem_ff[cmd.addr];
   end
endmodule

// ===== rtl/led_matrix_scroll_scanner_unit.sv =====
// LED matrix scroll scanner: a load transfer writes one glyph row byte, a tick transfer
// drives one scan column through S_OUT; a rebuilding tick first runs S_CUR/S_NXT per row,
// then S_LAST (16 RAM reads, one row byte a cycle, on the single glyph RAM port). Loads are
// taken one a cycle while in S_IDLE; no request is taken while a tick is in progress, and
// S_OUT waits for a free output register. Reset (synchronous) clears control and frame
// state and then clears all 512 glyph RAM bytes with req.ready held low.
module led_matrix_scroll_scanner_unit import lmss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lmss_req_if.sink          req,
   lmss_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0; // zero the glyph RAM after reset
   localparam logic [2:0] S_IDLE  = 3'd1; // take loads and ticks
   localparam logic [2:0] S_CUR   = 3'd2; // read current-slot row, retire previous row
   localparam logic [2:0] S_NXT   = 3'd3; // read next-slot row, capture current byte
   localparam logic [2:0] S_LAST  = 3'd4; // retire row 7, advance shift, slot on shift wrap
   localparam logic [2:0] S_OUT   = 3'd5; // hand the column to the output register

   cfg_type cfg;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PIX_W-1:0]    cur_ff, cur_in;
   logic [ROW_W-1:0]    shift_ff, shift_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [ROW_W-1:0]    scan_ff, scan_in;
   logic [PIX_W-1:0]    frame_ff [FRAME_ROWS];
   logic [PIX_W-1:0]    frame_in [FRAME_ROWS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    col_ff, col_in;
   logic [PIX_W-1:0]    rowdrv_ff, rowdrv_in;

   mem_cmd_type         mem_cmd;
   logic [PIX_W-1:0]    mem_rd;

   logic                req_xfer;
   logic                out_free;
   logic [SLOT_W:0]     slot_nxt_wide;
   logic                nxt_blank;
   logic [PIX_W-1:0]    nxt_byte;
   logic [PIX_W-1:0]    built;
   logic [PERIOD_W-1:0] elapsed_inc;
   logic [SLOT_W-1:0]   slot_adv;
   logic [PIX_W-1:0]    col_onehot;

   lmss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lmss_glyph_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (mem_rd)
   );

   assign req.ready    = (state_ff == S_IDLE);
   assign req_xfer     = req.valid && req.ready;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.column_drive = col_ff;
   assign rsp.row_drive    = rowdrv_ff;
   assign out_free     = !rsp_valid_ff || rsp.ready;

   // Next slot past the end of the store reads as a blank glyph
   assign slot_nxt_wide = {1'b0, slot_ff} + {{SLOT_W{1'b0}}, 1'b1};
   assign nxt_blank     = (slot_nxt_wide >= (SLOT_W+1)'(GLYPH_SLOTS));
   // mem_rd holds the next-slot byte in S_CUR and S_LAST
   assign nxt_byte      = nxt_blank ? '0 : mem_rd;
   assign built         = frame_byte(cur_ff, nxt_byte, shift_ff);

   // Saturating millisecond count
   assign elapsed_inc = (elapsed_ff != {PERIOD_W{1'b1}}) ? elapsed_ff + 1'b1 : elapsed_ff;

   // Slot advance wraps to zero past char_count or past the top of the index
   assign slot_adv = ((slot_nxt_wide[SLOT_W-1:0] == '0) ||
                      (slot_nxt_wide[SLOT_W-1:0] > cfg.char_count)) ?
                     '0 : slot_nxt_wide[SLOT_W-1:0];

   assign col_onehot = PIX_W'(1) << scan_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      row_in       = row_ff;
      cur_in       = cur_ff;
      shift_in     = shift_ff;
      slot_in      = slot_ff;
      elapsed_in   = elapsed_ff;
      scan_in      = scan_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff;
      col_in       = col_ff;
      rowdrv_in    = rowdrv_ff;
      mem_cmd.we    = 1'b0;
      mem_cmd.addr  = {slot_ff[SLOT_AW-1:0], row_ff};
      mem_cmd.wdata = req.row_bits;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.addr  = clr_addr_ff;
            mem_cmd.wdata = '0;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               if (req.operation == OP_LOAD) begin
                  mem_cmd.addr = {req.glyph_slot[SLOT_AW-1:0], req.glyph_row};
                  mem_cmd.we   = ({1'b0, req.glyph_slot} < (SLOT_W+1)'(GLYPH_SLOTS));
               end else if (elapsed_inc >= cfg.scroll_period) begin
                  elapsed_in = '0;
                  row_in     = '0;
                  state_in   = S_CUR;
               end else begin
                  elapsed_in = elapsed_inc;
                  state_in   = S_OUT;
               end
            end
         end
         S_CUR: begin
            mem_cmd.addr = {slot_ff[SLOT_AW-1:0], row_ff};
            if (row_ff != '0) begin
               frame_in[row_ff - 1'b1] = built;
            end
            state_in = S_NXT;
         end
         S_NXT: begin
            mem_cmd.addr = {slot_nxt_wide[SLOT_AW-1:0], row_ff};
            cur_in       = mem_rd;
            row_in       = row_ff + 1'b1;
            state_in     = (row_ff == {ROW_W{1'b1}}) ? S_LAST : S_CUR;
         end
         S_LAST: begin
            frame_in[FRAME_ROWS-1] = built;
            shift_in = shift_ff + 1'b1;
            if (shift_ff == {ROW_W{1'b1}}) begin
               slot_in = slot_adv;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               col_in       = cfg.columns_active_low ? ~col_onehot : col_onehot;
               rowdrv_in    = frame_ff[scan_ff];
               scan_in      = scan_ff + 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         row_ff       <= '0;
         shift_ff     <= '0;
         slot_ff      <= '0;
         elapsed_ff   <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FRAME_ROWS; i++) begin
            frame_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         row_ff       <= row_in;
         shift_ff     <= shift_in;
         slot_ff      <= slot_in;
         elapsed_ff   <= elapsed_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         frame_ff     <= frame_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      col_ff    <= col_in;
      rowdrv_ff <= rowdrv_in;
   end

   // No item is taken while the RAM is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req.ready)
      else $error("request accepted during clearing pass");

   // A tick always leads to a frame rebuild or straight to the output stage
   a_tick_next_state: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req.operation == OP_TICK) |=> (state_ff == S_CUR || state_ff == S_OUT))
      else $error("tick did not start rebuild or output");

   // Leaving the output stage always leaves a result waiting
   a_out_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("output stage left without a result");

   // Scan column moves only with a new result
   a_scan_with_result: assert property (@(posedge clock) disable iff (reset)
      (scan_ff != $past(scan_ff)) |-> ($past(state_ff) == S_OUT && rsp_valid_ff))
      else $error("scan column stepped without a result");

   // The shift only steps at the end of a rebuild
   a_shift_on_rebuild: assert property (@(posedge clock) disable iff (reset)
      (shift_ff != $past(shift_ff)) |-> ($past(state_ff) == S_LAST))
      else $error("shift changed outside a scroll step");
endmodule
